FILE: sv/atvv_pkg.sv
package atvv_pkg;

  localparam int TABLE_LEN   = 24;
  localparam int ONE_G_Q14   = 16384;
  localparam int VEL_GAIN    = 2633352;
  localparam int CORDIC_K    = 652032874;
  localparam int ANGLE_LIMIT = 23040;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_VEL  = 1'b1;

  localparam logic REG_RANGE = 1'b0;
  localparam logic REG_ANGLE = 1'b1;

  // CORDIC angle table, degrees * 2^16
  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD,
    ST_SQ_INIT, ST_SQ_RUN, ST_VEC_INIT, ST_VEC_RUN, ST_VEC_DONE,
    ST_ROT_INIT, ST_ROT_RUN, ST_ROT_DONE,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_SUM, ST_DELTA, ST_ACC,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture sample
    logic sq_init;     // start square root
    logic sq_step;
    logic vec_init;
    logic vec_step;
    logic vec_done;    // store angle
    logic rot_init;
    logic rot_step;
    logic rot_done;    // store sin/cos
    logic sel;         // 0 roll, 1 pitch
    logic [2:0] mstep; // multiply step, 0 none
    logic sum;
    logic delta;
    logic acc;
    logic clr_sat;
  } cmd_t;

  typedef struct packed {
    logic sq_last;
    logic cordic_last;
    logic angle_en;
  } sts_t;

endpackage

FILE: sv/atvv_ctrl.sv
module atvv_ctrl
  import atvv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic command,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    case (state_r)
      ST_IDLE: if (start) begin
        sel_nxt   = 1'b0;
        state_nxt = (command == CMD_LOAD) ? ST_LOAD : ST_ROT_INIT;
      end
      ST_LOAD:     state_nxt = sts.angle_en ? ST_SQ_INIT : ST_OUT;
      ST_SQ_INIT:  state_nxt = ST_SQ_RUN;
      ST_SQ_RUN:   if (sts.sq_last) state_nxt = ST_VEC_INIT;
      ST_VEC_INIT: state_nxt = ST_VEC_RUN;
      ST_VEC_RUN:  if (sts.cordic_last) state_nxt = ST_VEC_DONE;
      ST_VEC_DONE: begin
        sel_nxt   = 1'b1;
        state_nxt = sel_r ? ST_OUT : ST_SQ_INIT;
      end
      ST_ROT_INIT: state_nxt = ST_ROT_RUN;
      ST_ROT_RUN:  if (sts.cordic_last) state_nxt = ST_ROT_DONE;
      ST_ROT_DONE: begin
        sel_nxt   = 1'b1;
        state_nxt = sel_r ? ST_M1 : ST_ROT_INIT;
      end
      ST_M1:    state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_M4;
      ST_M4:    state_nxt = ST_M5;
      ST_M5:    state_nxt = ST_M6;
      ST_M6:    state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_DELTA;
      ST_DELTA: state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.sel  = sel_r;
    busy     = (state_r != ST_IDLE);
    done     = 1'b0;
    case (state_r)
      // capture the sample at the accepting edge
      ST_IDLE: begin
        cmd.clr_sat = start;
        cmd.load    = start && (command == CMD_LOAD);
      end
      ST_SQ_INIT:  cmd.sq_init  = 1'b1;
      ST_SQ_RUN:   cmd.sq_step  = 1'b1;
      ST_VEC_INIT: cmd.vec_init = 1'b1;
      ST_VEC_RUN:  cmd.vec_step = 1'b1;
      ST_VEC_DONE: cmd.vec_done = 1'b1;
      ST_ROT_INIT: cmd.rot_init = 1'b1;
      ST_ROT_RUN:  cmd.rot_step = 1'b1;
      ST_ROT_DONE: cmd.rot_done = 1'b1;
      ST_M1:       cmd.mstep    = 3'd1;
      ST_M2:       cmd.mstep    = 3'd2;
      ST_M3:       cmd.mstep    = 3'd3;
      ST_M4:       cmd.mstep    = 3'd4;
      ST_M5:       cmd.mstep    = 3'd5;
      ST_M6:       cmd.mstep    = 3'd6;
      ST_SUM:      cmd.sum      = 1'b1;
      ST_DELTA:    cmd.delta    = 1'b1;
      ST_ACC:      cmd.acc      = 1'b1;
      ST_OUT:      done         = out_free;
      default:     busy         = 1'b1;
    endcase
  end

endmodule

FILE: sv/atvv_dp.sv
module atvv_dp
  import atvv_pkg::*;
#(
  parameter int CORDIC_STEPS   = 16,
  parameter int VELOCITY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [15:0]        raw_x,
  input  logic [15:0]        raw_y,
  input  logic [15:0]        raw_z,
  input  logic [1:0]         accel_range,
  input  logic               angle_enable,
  output sts_t               sts,
  output logic signed [18:0] ax,
  output logic signed [18:0] ay,
  output logic signed [18:0] az,
  output logic signed [15:0] roll,
  output logic signed [15:0] pitch,
  output logic [31:0]        vel,
  output logic               sat
);

  localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int VW    = VELOCITY_WIDTH;
  // root operand is at most 2^57, 58 bits wide, so 29 result bits
  localparam int SQ_N  = 29;

  logic signed [18:0] sx_r, sy_r, sz_r;
  logic signed [15:0] roll_r, pitch_r;
  logic signed [VW-1:0] vacc_r;
  logic sat_r;

  // square root unit
  logic [57:0] sq_rem_r, sq_rem_nxt;
  logic [57:0] sq_op_r;
  logic [28:0] sq_root_r;
  logic [4:0]  sq_cnt_r;

  // shared CORDIC
  logic signed [33:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic [4:0]         ci_r;
  logic               vec_zero_r;

  logic signed [31:0] sr_r, cr_r, sp_r, cp_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] t1_r, t2_r, t3_r;
  logic signed [31:0] asum_r;
  logic signed [63:0] dprod_r;

  // numerator one bit wider so that negating the most negative value fits
  logic signed [19:0] num_s;
  logic signed [18:0] pa, pb;
  logic signed [37:0] sqa, sqb;
  logic [38:0]        sqsum;

  // pick operands for roll or pitch
  always_comb begin
    if (!cmd.sel) begin
      num_s = sy_r; pa = sx_r; pb = sz_r;
    end else begin
      num_s = -sx_r; pa = sy_r; pb = sz_r;
    end
    sqa   = pa * pa;
    sqb   = pb * pb;
    sqsum = {1'b0, sqa} + {1'b0, sqb};
  end

  // one root digit per cycle
  logic [57:0] trial;
  always_comb begin
    trial      = {sq_rem_r[55:0], sq_op_r[57:56]};
    sq_rem_nxt = trial - {27'd0, sq_root_r, 2'b01};
  end

  assign sts.sq_last     = (sq_cnt_r == 5'(SQ_N - 1));
  assign sts.cordic_last = (ci_r == 5'(NSTEP - 1));
  assign sts.angle_en    = angle_enable;

  logic signed [33:0] dx, dy;
  logic signed [31:0] at;
  logic signed [31:0] zr;
  logic signed [15:0] ang_sel;
  assign dx = cy_r >>> ci_r;
  assign dy = cx_r >>> ci_r;
  assign at = 32'(atan_lut(ci_r));
  assign zr = (cz_r + 32'sd128) >>> 8;
  assign ang_sel = cmd.sel ? pitch_r : roll_r;

  // multiply operand selection; chained products start once the first
  // factor has been rounded and registered
  logic signed [31:0] ma, mb;
  always_comb begin
    case (cmd.mstep)
      3'd1:    begin ma = 32'(sx_r); mb = sp_r; end
      3'd2:    begin ma = 32'(sy_r); mb = sr_r; end
      3'd3:    begin ma = 32'(sz_r); mb = cp_r; end
      3'd4:    begin ma = t2_r;      mb = cp_r; end
      3'd5:    begin ma = t3_r;      mb = cr_r; end
      default: begin ma = '0;        mb = '0;   end
    endcase
  end
  logic signed [31:0] rq;
  assign rq = 32'((prod_r + 64'sd536870912) >>> 30);

  logic signed [VW:0] vsum;
  logic signed [VW:0] vmax, vmin;
  logic signed [VW:0] dext;
  assign dext = (VW + 1)'((dprod_r + 64'sd8388608) >>> 24);
  assign vsum = {vacc_r[VW-1], vacc_r} + dext;
  assign vmax = (VW + 1)'({1'b0, {(VW - 1){1'b1}}});
  assign vmin = -vmax - 1;

  // control-side state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      roll_r <= '0; pitch_r <= '0;
      vacc_r <= '0;
      sat_r  <= 1'b0;
    end else begin
      if (cmd.clr_sat) sat_r <= 1'b0;
      if (cmd.load) begin
        sx_r <= 19'(signed'(raw_x)) <<< accel_range;
        sy_r <= 19'(signed'(raw_y)) <<< accel_range;
        sz_r <= 19'(signed'(raw_z)) <<< accel_range;
      end
      if (cmd.vec_done) begin
        logic signed [15:0] a;
        if (vec_zero_r) a = '0;
        else if (zr > 32'sd23040) a = 16'sd23040;
        else if (zr < -32'sd23040) a = -16'sd23040;
        else a = 16'(zr);
        if (cmd.sel) pitch_r <= a;
        else roll_r <= a;
      end
      if (cmd.acc) begin
        if (vsum > vmax) begin
          vacc_r <= VW'(vmax); sat_r <= 1'b1;
        end else if (vsum < vmin) begin
          vacc_r <= VW'(vmin); sat_r <= 1'b1;
        end else begin
          vacc_r <= VW'(vsum);
        end
      end
    end
  end

  // payload datapath
  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sq_op_r   <= {sqsum[37:0], 20'd0};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= '0;
    end
    if (cmd.sq_step) begin
      sq_op_r  <= {sq_op_r[55:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + 5'd1;
      if (!sq_rem_nxt[57]) begin
        sq_rem_r  <= sq_rem_nxt;
        sq_root_r <= {sq_root_r[27:0], 1'b1};
      end else begin
        sq_rem_r  <= trial;
        sq_root_r <= {sq_root_r[27:0], 1'b0};
      end
    end
    if (cmd.vec_init) begin
      cx_r <= 34'(sq_root_r);
      cy_r <= 34'(num_s) <<< 10;
      cz_r <= '0;
      ci_r <= '0;
      vec_zero_r <= (sq_root_r == '0) && (num_s == '0);
    end
    if (cmd.vec_step) begin
      ci_r <= ci_r + 5'd1;
      if (!cy_r[33]) begin
        cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - at;
      end
    end
    if (cmd.rot_init) begin
      cx_r <= 34'(CORDIC_K);
      cy_r <= '0;
      cz_r <= 32'(ang_sel) <<< 8;
      ci_r <= '0;
    end
    if (cmd.rot_step) begin
      ci_r <= ci_r + 5'd1;
      if (!cz_r[31]) begin
        cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + at;
      end
    end
    if (cmd.rot_done) begin
      if (cmd.sel) begin
        sp_r <= 32'(cy_r); cp_r <= 32'(cx_r);
      end else begin
        sr_r <= 32'(cy_r); cr_r <= 32'(cx_r);
      end
    end
    // one product per cycle, rounded the cycle after
    if (cmd.mstep != 3'd0) prod_r <= 64'(ma) * 64'(mb);
    case (cmd.mstep)
      3'd2: t1_r <= rq;
      3'd3: t2_r <= rq;
      3'd4: t3_r <= rq;
      3'd5: t2_r <= rq;
      3'd6: t3_r <= rq;
      default: ;
    endcase
    if (cmd.sum) asum_r <= t2_r + t3_r - t1_r - 32'(ONE_G_Q14);
    if (cmd.delta) dprod_r <= 64'(asum_r) * 64'(VEL_GAIN);
  end

  assign ax    = sx_r;
  assign ay    = sy_r;
  assign az    = sz_r;
  assign roll  = roll_r;
  assign pitch = pitch_r;
  assign vel   = 32'(vacc_r);
  assign sat   = sat_r;

endmodule

FILE: sv/accel_tilt_vertical_velocity_core.sv
// Accelerometer tilt and vertical velocity core.
// Input channel in_*: one word per command. tdata bit 0 is command (0 load
// sample, 1 integrate velocity step); raw_x/y/z follow as 16-bit signed.
// Output channel out_*: one result word per input word with stored accel
// (g Q.14), roll/pitch (deg Q7.8), velocity (Q16.16) and saturation flag.
// Sequence after the accepting edge: a load without angles registers the
// sample, then the result; a load with angles runs the square root and
// CORDIC vectoring for roll, then pitch; a velocity step runs CORDIC rotation
// for roll and pitch, the multiply steps, sum, delta and accumulate. One word
// is handled at a time; the next can be accepted in the cycle after the
// result is registered. Configuration: cfg_we with cfg_index 0 writes
// accel_range, 1 writes angle_enable; write only while idle.
// Reset (rst_n low, synchronous) clears accel, angles, velocity, the
// saturation flag and out_tvalid; range 0, angles enabled. If the receiver
// stalls the result holds in out_tdata; the next word is still accepted
// and processed, but its result waits until the held one is taken.
module accel_tilt_vertical_velocity_core
  import atvv_pkg::*;
#(
  parameter int CORDIC_STEPS   = 16,
  parameter int VELOCITY_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command, raw_x, raw_y, raw_z (zero padded to 56 bits)
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accel_x_g, accel_y_g, accel_z_g, roll_deg, pitch_deg, vertical_velocity,
  // velocity_saturated (zero padded to 128 bits)
  output logic [127:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [1:0]   cfg_wdata
);

  logic [1:0] range_r;
  logic       angle_en_r;
  cmd_t cmd;
  sts_t sts;
  logic busy, done, start;
  logic out_valid_r;
  logic [127:0] out_data_r;

  logic signed [18:0] ax, ay, az;
  logic signed [15:0] roll, pitch;
  logic [31:0] vel;
  logic sat;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r    <= 2'd0;
      angle_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE: range_r    <= cfg_wdata;
        REG_ANGLE: angle_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign start     = in_tvalid && in_tready;

  atvv_ctrl u_ctrl (
    .clk, .rst_n, .start, .command(in_tdata[0]),
    .out_free(!out_valid_r || out_tready), .sts, .cmd, .busy, .done
  );

  atvv_dp #(.CORDIC_STEPS(CORDIC_STEPS), .VELOCITY_WIDTH(VELOCITY_WIDTH)) u_dp (
    .clk, .rst_n, .cmd,
    .raw_x(in_tdata[16:1]), .raw_y(in_tdata[32:17]), .raw_z(in_tdata[48:33]),
    .accel_range(range_r), .angle_enable(angle_en_r), .sts,
    .ax, .ay, .az, .roll, .pitch, .vel, .sat
  );

  // output register; raw fields are captured at the accepting edge, so the
  // input word need not be held afterwards
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (done) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (done) out_data_r <= {6'd0, sat, vel, pitch, roll, az, ay, ax};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: tb/testbench.sv
module testbench;
  import atvv_pkg::*;

  localparam int  NSTEPS     = 16;
  localparam int  CYCLE_CAP  = 8000000;
  localparam int  DRAIN_WAIT = 120;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [55:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         cfg_we;
  logic         cfg_index;
  logic [1:0]   cfg_wdata;

  typedef struct packed {
    logic [18:0] ax;
    logic [18:0] ay;
    logic [18:0] az;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [31:0] vel;
    logic        sat;
  } motion_t;

  motion_t motion_q[$];

  // shadow of the block's registers and state
  int unsigned range_sh;
  bit          angle_en_sh;
  longint      acc_x, acc_y, acc_z, roll_sh, pitch_sh, vel_sh;

  longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};

  int  fail_count;
  int  checked_count;
  int  load_count;
  int  vel_count;
  int  clip_count;
  bit  no_idle;
  int  stall_left;
  longint cycles;

  accel_tilt_vertical_velocity_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(num / sqrt(a^2 + b^2)), degrees Q7.8
  function automatic longint tilt_deg(longint num, longint a, longint b);
    longint x, y, z, dx, dy, r;
    longint unsigned sq;
    sq = longint'(a * a) + longint'(b * b);
    x = longint'(int_sqrt(sq << 20));
    y = num * 1024;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end
    end
    r = (z + 128) >>> 8;
    if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
    if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
    return r;
  endfunction

  function automatic void rotate_deg(longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = CORDIC_K;
    y = 0;
    z = ang * 256;
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // advance the shadow state by one word and return the expected result
  function automatic motion_t predict_motion(logic cmd, logic signed [15:0] rx,
                                             logic signed [15:0] ry,
                                             logic signed [15:0] rz);
    motion_t m;
    longint sr, cr, sp, cp, a, delta, sum;
    longint vmax, vmin;
    bit clip;
    clip = 1'b0;
    if (cmd == CMD_LOAD) begin
      acc_x = longint'(rx) * (64'sd1 <<< range_sh);
      acc_y = longint'(ry) * (64'sd1 <<< range_sh);
      acc_z = longint'(rz) * (64'sd1 <<< range_sh);
      if (angle_en_sh) begin
        roll_sh  = tilt_deg(acc_y, acc_x, acc_z);
        pitch_sh = tilt_deg(-acc_x, acc_y, acc_z);
      end
      load_count++;
    end else begin
      vmax = (64'sd1 <<< 31) - 1;
      vmin = -vmax - 1;
      rotate_deg(roll_sh, sr, cr);
      rotate_deg(pitch_sh, sp, cp);
      a = -q30_mul(acc_x, sp) + q30_mul(q30_mul(acc_y, sr), cp)
          + q30_mul(q30_mul(acc_z, cp), cr) - ONE_G_Q14;
      delta = (a * VEL_GAIN + (64'sd1 <<< 23)) >>> 24;
      sum = vel_sh + delta;
      if (sum > vmax) begin sum = vmax; clip = 1'b1; end
      if (sum < vmin) begin sum = vmin; clip = 1'b1; end
      vel_sh = sum;
      vel_count++;
      if (clip) clip_count++;
    end
    m.ax    = acc_x[18:0];
    m.ay    = acc_y[18:0];
    m.az    = acc_z[18:0];
    m.roll  = roll_sh[15:0];
    m.pitch = pitch_sh[15:0];
    m.vel   = vel_sh[31:0];
    m.sat   = clip;
    return m;
  endfunction

  // send one word; valid stays high into the next call when no gap follows
  task automatic send_word(logic cmd, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, rz, ry, rx, cmd};
    do @(posedge clk); while (!in_tready);
    motion_q.push_back(predict_motion(cmd, rx, ry, rz));
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RANGE) range_sh = val;
    else angle_en_sh = val[0];
  endtask

  task automatic send_load(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
    send_word(CMD_LOAD, rx, ry, rz);
  endtask

  task automatic send_vel();
    send_word(CMD_VEL, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    motion_t exp_m, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[18:0], out_tdata[37:19], out_tdata[56:38], out_tdata[72:57],
             out_tdata[88:73], out_tdata[120:89], out_tdata[121]};
      if (motion_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        exp_m = motion_q.pop_front();
        checked_count++;
        if (got.ax !== exp_m.ax) begin
          $error("accel_x_g expected %0d got %0d", $signed(exp_m.ax), $signed(got.ax));
          fail_count++;
        end
        if (got.ay !== exp_m.ay) begin
          $error("accel_y_g expected %0d got %0d", $signed(exp_m.ay), $signed(got.ay));
          fail_count++;
        end
        if (got.az !== exp_m.az) begin
          $error("accel_z_g expected %0d got %0d", $signed(exp_m.az), $signed(got.az));
          fail_count++;
        end
        if (got.roll !== exp_m.roll) begin
          $error("roll_deg expected %0d got %0d", $signed(exp_m.roll), $signed(got.roll));
          fail_count++;
        end
        if (got.pitch !== exp_m.pitch) begin
          $error("pitch_deg expected %0d got %0d", $signed(exp_m.pitch),
                 $signed(got.pitch));
          fail_count++;
        end
        if (got.vel !== exp_m.vel) begin
          $error("vertical_velocity expected %0d got %0d", $signed(exp_m.vel),
                 $signed(got.vel));
          fail_count++;
        end
        if (got.sat !== exp_m.sat) begin
          $error("velocity_saturated expected %0d got %0d", exp_m.sat, got.sat);
          fail_count++;
        end
      end
    end
  end

  // extremes, zero and vertical vectors at reset settings, then range 3 cases
  task automatic test_directed();
    send_load(16'h7fff, 16'h7fff, 16'h7fff);
    send_vel();
    send_load(16'h8000, 16'h8000, 16'h8000);
    send_vel();
    send_load(16'h0000, 16'h0000, 16'h0000);
    send_vel();
    send_load(16'h0000, 16'h7fff, 16'h0000);
    send_vel();
    send_load(16'h0000, 16'h8000, 16'h0000);
    send_load(16'h8000, 16'h0000, 16'h0000);
    send_vel();
    send_load(16'h7fff, 16'h0000, 16'h0000);
    send_load(16'h0001, 16'hffff, 16'h0000);
    send_vel();
    send_load(16'h0000, 16'h0000, 16'h4000);
    send_vel();
    send_vel();
    write_reg(REG_RANGE, 2'd3);
    send_load(16'h8000, 16'h7fff, 16'h8000);
    send_vel();
    send_load(16'h0000, 16'h0000, 16'h0000);
    send_vel();
  endtask

  // stale angles are kept and used by velocity steps
  task automatic test_angles_off();
    write_reg(REG_RANGE, 2'd1);
    send_load(16'h2000, 16'he000, 16'h3000);
    write_reg(REG_ANGLE, 2'd0);
    send_load(16'h8000, 16'h7fff, 16'h0100);
    send_vel();
    send_load(16'h0000, 16'h0000, 16'h0000);
    send_vel();
    write_reg(REG_ANGLE, 2'd1);
  endtask

  // back-to-back velocity steps with the largest downward acceleration,
  // driving the accumulator toward the negative limit with stale angles
  task automatic test_clip();
    int start_clips;
    no_idle = 1'b1;
    write_reg(REG_RANGE, 2'd3);
    send_load(16'h7fff, 16'h7fff, 16'h7fff);
    write_reg(REG_ANGLE, 2'd0);
    send_load(16'h8000, 16'h8000, 16'h8000);
    start_clips = clip_count;
    for (int n = 0; n < 150 && clip_count < start_clips + 3; n++) send_vel();
    write_reg(REG_ANGLE, 2'd1);
    no_idle = 1'b0;
  endtask

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1:       return 16'd0;
      2:       return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  // random loads and velocity steps across every range and angle setting
  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_RANGE, 2'(p % 4));
      write_reg(REG_ANGLE, 2'(p < 4 ? 1 : (p % 2)));
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 1)) send_load(rand_raw(), rand_raw(), rand_raw());
        else send_vel();
        if ($urandom_range(0, 99) == 0) drain();
      end
    end
    drain();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_RANGE;
    cfg_wdata   = 2'd0;
    cycles      = 0;
    fail_count  = 0;
    no_idle     = 1'b0;
    range_sh    = 0;
    angle_en_sh = 1'b1;
    acc_x = 0; acc_y = 0; acc_z = 0;
    roll_sh = 0; pitch_sh = 0; vel_sh = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_angles_off();
    test_clip();
    test_random();

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Checked %0d words: %0d sample loads, %0d velocity steps, %0d clipped.",
             checked_count, load_count, vel_count, clip_count);
    $display("Covered all ranges, angles on and off, zero and vertical vectors.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
